// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, sampled on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GTP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define GTP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/gtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtp_pkg
// Types, constants and helpers of the guillotine rectangle packer.
// ----------------------------------------------------------------------------
package gtp_pkg;

   localparam int MAX_DIM = 2048;
   localparam int PAD     = 4;
   localparam int ALIGN   = 128;

   localparam int REQ_W = 12;
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int PW_W  = REQ_W + 1;
   localparam int POS_W = 11;
   localparam int FC_W  = 7;
   localparam int STS_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic REG_ATLAS_W = 1'b0;
   localparam logic REG_ATLAS_H = 1'b1;

   typedef enum logic [STS_W-1:0] {
      STS_OK     = 2'd0,
      STS_NO_FIT = 2'd1,
      STS_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_CHECK,
      ST_MODIFY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } rect_type;

   typedef struct packed {
      logic     shift;
      logic     load0;
      rect_type push;
      rect_type root;
   } chain_ctl_type;

   function automatic logic [DIM_W-1:0] round_dim(input logic [REQ_W-1:0] v);
      logic [REQ_W:0] sum;
      logic [REQ_W:0] r;
      sum = {1'b0, v} + (REQ_W+1)'(ALIGN - 1);
      r   = sum & ~((REQ_W+1)'(ALIGN - 1));
      if (r > (REQ_W+1)'(MAX_DIM)) begin
         r = (REQ_W+1)'(MAX_DIM);
      end
      return DIM_W'(r);
   endfunction

endpackage

// ===== hw/rtl/guillotine_rect_packer_top.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_packer_top
// First-fit guillotine allocator for a texture atlas over a ring of cells.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | tdata: req_width, req_height; tuser: opcode
//  rsp_    | out       | tdata: pos_x, pos_y, free_count; tuser: status
//  csr_    | in        | index 0 atlas_width, index 1 atlas_height
//
//  Insert: a search pass of one full rotation of the cell ring, a check, then
//  a rewrite pass of one more rotation; the result is then registered, and the
//  next word can be taken in the same cycle that the result becomes valid.
//  No fit or list full: the search pass and check only, no rewrite. Clear:
//  loads the root rectangle and goes straight to the result. Reset loads the root rectangle into the head cell.
//  A waiting result holds the block in its final state until rsp_tready.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_top #(
   parameter int MAX_FREE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // req_width, req_height
   input  logic                          req_tuser,   // opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // pos_x, pos_y, free_count
   output logic [gtp_pkg::STS_W-1:0]     rsp_tuser,   // status
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [gtp_pkg::REQ_W-1:0]     csr_wdata
);
   import gtp_pkg::*;

   `include "assert_macros.svh"

   chain_ctl_type ctl;
   rect_type      cell_q [MAX_FREE];

   gtp_ctrl #(
      .MAX_FREE (MAX_FREE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head       (cell_q[0]),
      .next       (cell_q[1]),
      .ctl        (ctl)
   );

   for (genvar i = 0; i < MAX_FREE; i++) begin : g_cell
      rect_type d_in;
      if (i == MAX_FREE - 1) begin : g_tail
         assign d_in = ctl.push;
      end else begin : g_mid
         assign d_in = cell_q[i+1];
      end
      gtp_cell u_cell (
         .clock      (clock),
         .shift      (ctl.shift),
         .load       ((i == 0) ? ctl.load0 : 1'b0),
         .load_data  (ctl.root),
         .shift_data (d_in),
         .data_out   (cell_q[i])
      );
   end

   `GTP_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `GTP_ASSERT_IMP(a_no_shift_on_load, ctl.load0, !ctl.shift)
   `GTP_ASSERT_IMP(a_count_bound, rsp_tvalid, rsp_tdata[28:22] <= FC_W'(MAX_FREE))
   `GTP_ASSERT_IMP(a_fail_no_pos, rsp_tvalid && (rsp_tuser != STS_OK), rsp_tdata[21:0] == '0)

endmodule

// ===== hw/rtl/gtp_cell.sv =====
// ----------------------------------------------------------------------------
// gtp_cell
// One free-list slot: holds a rectangle, takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module gtp_cell (
   input  logic              clock,
   input  logic              shift,
   input  logic              load,
   input  gtp_pkg::rect_type load_data,
   input  gtp_pkg::rect_type shift_data,
   output gtp_pkg::rect_type data_out
);
   import gtp_pkg::*;

   rect_type data_ff;
   rect_type data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (shift) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== hw/rtl/gtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer: search pass and rewrite pass over the cell ring, result register.
// ----------------------------------------------------------------------------
module gtp_ctrl #(
   parameter int MAX_FREE = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   output logic [gtp_pkg::STS_W-1:0]       rsp_tuser,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [gtp_pkg::REQ_W-1:0]       csr_wdata,
   input  gtp_pkg::rect_type               head,
   input  gtp_pkg::rect_type               next,
   output gtp_pkg::chain_ctl_type          ctl
);
   import gtp_pkg::*;

   localparam int IDX_W = $clog2(MAX_FREE);
   localparam int CNT_W = $clog2(MAX_FREE + 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             found_ff, found_in;
   rect_type         fnd_ff, fnd_in;
   logic [PW_W-1:0]  pw_ff, pw_in;
   logic [PW_W-1:0]  ph_ff, ph_in;
   status_type       res_sts_ff, res_sts_in;
   logic [POS_W-1:0] res_x_ff, res_x_in;
   logic [POS_W-1:0] res_y_ff, res_y_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_sts_ff, rsp_sts_in;
   logic [POS_W-1:0] rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0] rsp_y_ff, rsp_y_in;
   logic [FC_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [REQ_W-1:0] atlas_w_ff, atlas_w_in;
   logic [REQ_W-1:0] atlas_h_ff, atlas_h_in;

   logic             last_step;
   logic [CNT_W-1:0] k_ext;
   logic             fits;
   logic             has_right;
   logic             has_bottom;
   logic [CNT_W:0]   new_n;
   rect_type         right_rect;
   rect_type         bottom_rect;
   rect_type         slot0;
   rect_type         slot1;

   assign last_step = (k_ff == IDX_W'(MAX_FREE - 1));
   assign k_ext     = CNT_W'(k_ff);
   assign fits      = (pw_ff <= PW_W'(head.w)) && (ph_ff <= PW_W'(head.h));

   assign has_right  = (PW_W'(fnd_ff.w) > pw_ff) && (ph_ff != '0);
   assign has_bottom = (fnd_ff.w != '0) && (PW_W'(fnd_ff.h) > ph_ff);
   assign new_n      = (CNT_W+1)'(n_ff) - (CNT_W+1)'(1)
                     + (CNT_W+1)'(has_right) + (CNT_W+1)'(has_bottom);

   always_comb begin
      right_rect.x  = fnd_ff.x + DIM_W'(pw_ff);
      right_rect.y  = fnd_ff.y;
      right_rect.w  = fnd_ff.w - DIM_W'(pw_ff);
      right_rect.h  = DIM_W'(ph_ff);
      bottom_rect.x = fnd_ff.x;
      bottom_rect.y = fnd_ff.y + DIM_W'(ph_ff);
      bottom_rect.w = fnd_ff.w;
      bottom_rect.h = fnd_ff.h - DIM_W'(ph_ff);
      slot0 = has_right ? right_rect : (has_bottom ? bottom_rect : head);
      slot1 = (has_right && has_bottom) ? bottom_rect : head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         k_ff         <= '0;
         n_ff         <= CNT_W'(1);
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         atlas_w_ff   <= REQ_W'(MAX_DIM);
         atlas_h_ff   <= REQ_W'(MAX_DIM);
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         atlas_w_ff   <= atlas_w_in;
         atlas_h_ff   <= atlas_h_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      fnd_ff     <= fnd_in;
      pw_ff      <= pw_in;
      ph_ff      <= ph_in;
      res_sts_ff <= res_sts_in;
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      rsp_sts_ff <= rsp_sts_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      found_in     = found_ff;
      fnd_in       = fnd_ff;
      pw_in        = pw_ff;
      ph_in        = ph_ff;
      res_sts_in   = res_sts_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sts_in   = rsp_sts_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      atlas_w_in   = atlas_w_ff;
      atlas_h_in   = atlas_h_ff;
      req_tready   = 1'b0;
      ctl.shift    = 1'b0;
      ctl.load0    = 1'b0;
      ctl.push     = head;
      ctl.root.x   = '0;
      ctl.root.y   = '0;
      ctl.root.w   = round_dim(atlas_w_ff);
      ctl.root.h   = round_dim(atlas_h_ff);

      if (csr_we) begin
         if (csr_index == REG_ATLAS_W) begin
            atlas_w_in = csr_wdata;
         end else begin
            atlas_h_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_INIT: begin
            ctl.load0 = 1'b1;
            n_in      = CNT_W'(1);
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pw_in    = PW_W'(req_tdata[REQ_W-1:0]) + PW_W'(2 * PAD);
               ph_in    = PW_W'(req_tdata[2*REQ_W-1:REQ_W]) + PW_W'(2 * PAD);
               res_x_in = '0;
               res_y_in = '0;
               k_in     = '0;
               found_in = 1'b0;
               if (req_tuser == OP_CLEAR) begin
                  ctl.load0  = 1'b1;
                  n_in       = CNT_W'(1);
                  res_sts_in = STS_OK;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            ctl.shift = 1'b1;
            if (!found_ff && (k_ext < n_ff) && fits) begin
               found_in = 1'b1;
               idx_in   = k_ff;
               fnd_in   = head;
            end
            k_in = k_ff + IDX_W'(1);
            if (last_step) begin
               k_in     = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!found_ff) begin
               res_sts_in = STS_NO_FIT;
               state_in   = ST_DONE;
            end else if (new_n > (CNT_W+1)'(MAX_FREE)) begin
               res_sts_in = STS_FULL;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            ctl.shift = 1'b1;
            if (k_ext < CNT_W'(idx_ff)) begin
               ctl.push = head;
            end else if (k_ext + CNT_W'(1) < n_ff) begin
               ctl.push = next;
            end else if (k_ext + CNT_W'(1) == n_ff) begin
               ctl.push = slot0;
            end else if (k_ext == n_ff) begin
               ctl.push = slot1;
            end else begin
               ctl.push = head;
            end
            k_in = k_ff + IDX_W'(1);
            if (last_step) begin
               k_in       = '0;
               n_in       = CNT_W'(new_n);
               res_sts_in = STS_OK;
               res_x_in   = POS_W'((DIM_W+1)'(fnd_ff.x) + (DIM_W+1)'(PAD));
               res_y_in   = POS_W'((DIM_W+1)'(fnd_ff.y) + (DIM_W+1)'(PAD));
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_sts_in   = res_sts_ff;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_cnt_in   = FC_W'(n_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sts_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_y_ff, rsp_x_ff};

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the guillotine rectangle packer. Insert and clear
// words go in with random gaps while the response side stalls at random;
// each placement is predicted from a local copy of the free list and the
// atlas size, and every response word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import gtp_pkg::*;

   localparam int FREE_DEPTH    = 64;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 2 * FREE_DEPTH + 20;
   localparam int RANDOM_BLOCKS = 16;
   localparam int BLOCK_ITEMS   = 92;

   typedef struct {
      status_type       status;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [FC_W-1:0]  free_count;
   } placement_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata  = '0;
   logic              req_tuser  = OP_INSERT;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [STS_W-1:0]  rsp_tuser;
   logic              csr_we     = 1'b0;
   logic              csr_index  = REG_ATLAS_W;
   logic [REQ_W-1:0]  csr_wdata  = '0;

   // free list mirror
   logic [PW_W-1:0]   slot_x [FREE_DEPTH];
   logic [PW_W-1:0]   slot_y [FREE_DEPTH];
   logic [PW_W-1:0]   slot_w [FREE_DEPTH];
   logic [PW_W-1:0]   slot_h [FREE_DEPTH];
   int                free_slots;
   logic [REQ_W-1:0]  atlas_w_reg;
   logic [REQ_W-1:0]  atlas_h_reg;

   placement_type     placements_due[$];
   status_type        last_status;
   bit                idle_on     = 1'b1;
   int                hold_off    = 0;
   int unsigned       errors      = 0;
   int unsigned       cycle_count = 0;
   int unsigned       words_sent, words_checked;
   int unsigned       n_placed, n_nofit, n_full, n_clear, atlas_writes, peak_slots;

   guillotine_rect_packer_top #(
      .MAX_FREE(FREE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic logic [PW_W-1:0] snap_dim(input logic [REQ_W-1:0] v);
      logic [PW_W-1:0] r;
      r = ({1'b0, v} + PW_W'(ALIGN - 1)) & ~PW_W'(ALIGN - 1);
      if (r > PW_W'(MAX_DIM)) begin
         r = PW_W'(MAX_DIM);
      end
      return r;
   endfunction

   function automatic void rebuild_root();
      slot_x[0]  = '0;
      slot_y[0]  = '0;
      slot_w[0]  = snap_dim(atlas_w_reg);
      slot_h[0]  = snap_dim(atlas_h_reg);
      free_slots = 1;
   endfunction

   function automatic placement_type allocate_rect(input logic op,
                                                   input logic [REQ_W-1:0] w,
                                                   input logic [REQ_W-1:0] h);
      placement_type   res;
      logic [PW_W-1:0] pw, ph, fx, fy, fw, fh;
      logic            has_right, has_bottom;
      int              i, hit, n;
      res.status     = STS_OK;
      res.pos_x      = '0;
      res.pos_y      = '0;
      res.free_count = '0;
      if (op == OP_CLEAR) begin
         rebuild_root();
         n_clear++;
         res.free_count = FC_W'(1);
         return res;
      end
      pw  = {1'b0, w} + PW_W'(2 * PAD);
      ph  = {1'b0, h} + PW_W'(2 * PAD);
      n   = free_slots;
      hit = -1;
      for (i = 0; i < n; i++) begin
         if (hit < 0 && pw <= slot_w[i] && ph <= slot_h[i]) begin
            hit = i;
         end
      end
      if (hit < 0) begin
         res.status     = STS_NO_FIT;
         res.free_count = FC_W'(n);
         n_nofit++;
         return res;
      end
      fx = slot_x[hit];
      fy = slot_y[hit];
      fw = slot_w[hit];
      fh = slot_h[hit];
      has_right  = (fw > pw) && (ph != 0);
      has_bottom = (fw != 0) && (fh > ph);
      if ((n - 1) + int'(has_right) + int'(has_bottom) > FREE_DEPTH) begin
         res.status     = STS_FULL;
         res.free_count = FC_W'(n);
         n_full++;
         return res;
      end
      for (i = hit; i + 1 < n; i++) begin
         slot_x[i] = slot_x[i+1];
         slot_y[i] = slot_y[i+1];
         slot_w[i] = slot_w[i+1];
         slot_h[i] = slot_h[i+1];
      end
      n--;
      if (has_right) begin
         slot_x[n] = fx + pw;
         slot_y[n] = fy;
         slot_w[n] = fw - pw;
         slot_h[n] = ph;
         n++;
      end
      if (has_bottom) begin
         slot_x[n] = fx;
         slot_y[n] = fy + ph;
         slot_w[n] = fw;
         slot_h[n] = fh - ph;
         n++;
      end
      free_slots = n;
      if (n > peak_slots) begin
         peak_slots = n;
      end
      n_placed++;
      res.pos_x      = POS_W'(fx + PAD);
      res.pos_y      = POS_W'(fy + PAD);
      res.free_count = FC_W'(n);
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!idle_on) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end else begin
         return $urandom_range(20, 40);
      end
   endfunction

   task automatic send_request(input logic op, input logic [REQ_W-1:0] w,
                               input logic [REQ_W-1:0] h);
      int            gap;
      placement_type due;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {h, w};
      do @(posedge clock); while (!req_tready);
      due            = allocate_rect(op, w, h);
      last_status    = due.status;
      placements_due = {placements_due, due};
      words_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_atlas(input logic [REQ_W-1:0] w, input logic [REQ_W-1:0] h);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= REG_ATLAS_W;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= REG_ATLAS_H;
      csr_wdata <= h;
      @(posedge clock);
      csr_we      <= 1'b0;
      atlas_w_reg  = w;
      atlas_h_reg  = h;
      atlas_writes++;
   endtask

   task automatic check_placement(input placement_type got);
      placement_type want;
      if (placements_due.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("unexpected response word: status %0d x %0d y %0d free %0d",
                     got.status, got.pos_x, got.pos_y, got.free_count);
         end
         return;
      end
      want = placements_due.pop_front();
      if (got.status != want.status || got.pos_x != want.pos_x ||
          got.pos_y != want.pos_y || got.free_count != want.free_count) begin
         errors++;
         if (errors <= 10) begin
            $display("response %0d: expected status %0d x %0d y %0d free %0d",
                     words_checked, want.status, want.pos_x, want.pos_y,
                     want.free_count);
            $display("response %0d:      got status %0d x %0d y %0d free %0d",
                     words_checked, got.status, got.pos_x, got.pos_y,
                     got.free_count);
         end
      end
      words_checked++;
   endtask

   initial begin : rsp_side
      int            stall;
      placement_type got;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tuser);
            got.pos_x      = rsp_tdata[10:0];
            got.pos_y      = rsp_tdata[21:11];
            got.free_count = rsp_tdata[28:22];
            check_placement(got);
         end
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            hold_off--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
               stall = pick_gap();
            end
         end
      end
   end

   task automatic test_reset_root();
      send_request(OP_INSERT, 12'd0, 12'd0);
      send_request(OP_INSERT, 12'd4095, 12'd4095);
      send_request(OP_INSERT, 12'd2048, 12'd0);
      send_request(OP_INSERT, 12'd0, 12'd2048);
      send_request(OP_INSERT, 12'd2031, 12'd1000);
   endtask

   task automatic test_clear_and_exact_fit();
      send_request(OP_CLEAR, 12'd4095, 12'd4095);
      send_request(OP_INSERT, 12'd2040, 12'd2040);
      send_request(OP_INSERT, 12'd0, 12'd0);
      send_request(OP_CLEAR, 12'd0, 12'd0);
   endtask

   task automatic test_atlas_rounding();
      set_atlas(12'd1, 12'd1);
      send_request(OP_CLEAR, 12'd0, 12'd0);
      send_request(OP_INSERT, 12'd120, 12'd120);
      send_request(OP_CLEAR, 12'd0, 12'd0);
      send_request(OP_INSERT, 12'd121, 12'd0);
      set_atlas(12'd0, 12'd2048);
      send_request(OP_CLEAR, 12'd0, 12'd0);
      send_request(OP_INSERT, 12'd0, 12'd0);
      set_atlas(12'd4095, 12'd4095);
      send_request(OP_CLEAR, 12'd0, 12'd0);
      send_request(OP_INSERT, 12'd2040, 12'd2040);
      set_atlas(12'd129, 12'd2047);
      send_request(OP_CLEAR, 12'd0, 12'd0);
      send_request(OP_INSERT, 12'd248, 12'd10);
      set_atlas(12'd2048, 12'd2048);
      send_request(OP_CLEAR, 12'd0, 12'd0);
   endtask

   task automatic test_list_full();
      int k, extra;
      extra = -1;
      send_request(OP_CLEAR, 12'd0, 12'd0);
      for (k = 0; k < 600 && extra != 0; k++) begin
         send_request(OP_INSERT, REQ_W'($urandom_range(0, 30)),
                      REQ_W'($urandom_range(0, 30)));
         if (extra > 0) begin
            extra--;
         end else if (extra < 0 && last_status == STS_FULL) begin
            extra = 3;
         end
      end
   endtask

   task automatic test_backpressure();
      int k;
      wait_idle();
      idle_on  = 1'b0;
      hold_off = 400;
      for (k = 0; k < 8; k++) begin
         send_request(OP_INSERT, REQ_W'($urandom_range(0, 60)),
                      REQ_W'($urandom_range(0, 60)));
      end
      wait_idle();
      idle_on = 1'b1;
   endtask

   function automatic logic [REQ_W-1:0] random_atlas_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return REQ_W'($urandom_range(1024, 2048));
      end else if (roll < 85) begin
         return REQ_W'($urandom_range(0, 2048));
      end else begin
         return REQ_W'($urandom_range(0, 4095));
      end
   endfunction

   function automatic logic [REQ_W-1:0] random_side();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return REQ_W'($urandom_range(0, 120));
      end else if (roll < 90) begin
         return REQ_W'($urandom_range(0, 700));
      end else if (roll < 97) begin
         return REQ_W'($urandom_range(0, 2048));
      end else begin
         return REQ_W'($urandom_range(0, 4095));
      end
   endfunction

   task automatic test_random_traffic();
      int blk, k;
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         idle_on = (blk % 4 != 2);
         if (blk % 2 == 0) begin
            set_atlas(random_atlas_dim(), random_atlas_dim());
         end
         send_request(OP_CLEAR, REQ_W'($urandom_range(0, 4095)),
                      REQ_W'($urandom_range(0, 4095)));
         for (k = 0; k < BLOCK_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 4) begin
               send_request(OP_CLEAR, random_side(), random_side());
            end else begin
               send_request(OP_INSERT, random_side(), random_side());
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      atlas_w_reg = REQ_W'(MAX_DIM);
      atlas_h_reg = REQ_W'(MAX_DIM);
      rebuild_root();
      peak_slots = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_root();
      test_clear_and_exact_fit();
      test_atlas_rounding();
      test_list_full();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d words sent, %0d checked: %0d placed, %0d no fit, %0d full, %0d clears",
               words_sent, words_checked, n_placed, n_nofit, n_full, n_clear);
      $display("%0d atlas sizes written, free list reached %0d entries",
               atlas_writes, peak_slots);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
